FILE: hw/rtl/fpp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed packet parser.
package fpp_pkg;

  localparam logic [7:0]  SYNC_RESET = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Register byte index (paddr[2]) of the one configuration register.
  localparam logic REG_SYNC_BYTE = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_SENDER = 3'd2,
    PH_LEN    = 3'd3,
    PH_MSG    = 3'd4,
    PH_CRC    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_GOOD    = 2'd2,
    EV_CRC_ERR = 2'd3
  } event_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] message_type;
    logic [15:0] src_id;
    logic [7:0]  payload_len;
  } result_t;

  // CRC-16 XMODEM, MSB first, one byte per call.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/fpp_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
module fpp_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // rx_byte[7:0]
  output fpp_pkg::in_item_t item,
  input  logic              take
);

  logic       valid;
  logic [7:0] rx_byte;

  assign s_tready = !valid || take;
  assign item     = '{valid: valid, rx_byte: rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata;
    end
  end

endmodule

FILE: hw/rtl/fpp_parser.sv
// Frame parser: phase tracking, header capture, running CRC and the result register.
module fpp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        sync_byte,
  input  fpp_pkg::in_item_t item,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output fpp_pkg::result_t  res
);

  fpp_pkg::phase_t  phase, phase_next;
  logic [7:0]       byte_count, byte_count_next;
  logic [15:0]      type_reg, type_reg_next;
  logic [15:0]      sender_reg, sender_reg_next;
  logic [7:0]       length_reg, length_reg_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       crc_low_byte, crc_low_byte_next;
  fpp_pkg::result_t res_next;

  logic [15:0] crc_upd;
  logic [7:0]  count_inc;
  logic [7:0]  b;

  assign take      = item.valid && (!res_valid || res_ready);
  assign b         = item.rx_byte;
  assign crc_upd   = fpp_pkg::crc16_feed(running_crc, b);
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    type_reg_next     = type_reg;
    sender_reg_next   = sender_reg;
    length_reg_next   = length_reg;
    running_crc_next  = running_crc;
    crc_low_byte_next = crc_low_byte;
    res_next          = '{event_res: fpp_pkg::EV_NONE, default: '0};

    case (phase)
      fpp_pkg::PH_HUNT: begin
        if (b == sync_byte) begin
          phase_next       = fpp_pkg::PH_TYPE;
          byte_count_next  = 8'd0;
          running_crc_next = 16'd0;
        end
      end
      fpp_pkg::PH_TYPE: begin
        running_crc_next = crc_upd;
        if (byte_count == 8'd0) begin
          type_reg_next   = {type_reg[15:8], b};
          byte_count_next = 8'd1;
        end else begin
          type_reg_next   = {b, type_reg[7:0]};
          byte_count_next = 8'd0;
          phase_next      = fpp_pkg::PH_SENDER;
        end
      end
      fpp_pkg::PH_SENDER: begin
        running_crc_next = crc_upd;
        if (byte_count == 8'd0) begin
          sender_reg_next = {sender_reg[15:8], b};
          byte_count_next = 8'd1;
        end else begin
          sender_reg_next = {b, sender_reg[7:0]};
          byte_count_next = 8'd0;
          phase_next      = fpp_pkg::PH_LEN;
        end
      end
      fpp_pkg::PH_LEN: begin
        running_crc_next = crc_upd;
        length_reg_next  = b;
        byte_count_next  = 8'd0;
        // zero length skips straight to the CRC bytes
        phase_next       = (b == 8'd0) ? fpp_pkg::PH_CRC : fpp_pkg::PH_MSG;
      end
      fpp_pkg::PH_MSG: begin
        running_crc_next      = crc_upd;
        res_next.event_res    = fpp_pkg::EV_PAYLOAD;
        res_next.data_byte    = b;
        res_next.byte_index   = byte_count;
        res_next.message_type = type_reg;
        res_next.src_id       = sender_reg;
        res_next.payload_len  = length_reg;
        if (count_inc >= length_reg) begin
          byte_count_next = 8'd0;
          phase_next      = fpp_pkg::PH_CRC;
        end else begin
          byte_count_next = count_inc;
        end
      end
      fpp_pkg::PH_CRC: begin
        if (byte_count == 8'd0) begin
          crc_low_byte_next = b;
          byte_count_next   = 8'd1;
        end else begin
          res_next.event_res    = ({b, crc_low_byte} == running_crc) ?
                                  fpp_pkg::EV_GOOD : fpp_pkg::EV_CRC_ERR;
          res_next.message_type = type_reg;
          res_next.src_id       = sender_reg;
          res_next.payload_len  = length_reg;
          byte_count_next       = 8'd0;
          phase_next            = fpp_pkg::PH_HUNT;
        end
      end
      default: begin
        // unused phase code: drop the byte and go back to hunting
        phase_next      = fpp_pkg::PH_HUNT;
        byte_count_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fpp_pkg::PH_HUNT;
      byte_count   <= 8'd0;
      type_reg     <= 16'd0;
      sender_reg   <= 16'd0;
      length_reg   <= 8'd0;
      running_crc  <= 16'd0;
      crc_low_byte <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      type_reg     <= type_reg_next;
      sender_reg   <= sender_reg_next;
      length_reg   <= length_reg_next;
      running_crc  <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/framed_packet_parser_crc16.sv
// Top level of the framed packet parser: APB register, input stage, parser.
//
// Input stream (s_*): one received byte per item in s_tdata. The parser hunts
// for the sync byte, then reads type (2 bytes, LE), sender id (2 bytes, LE),
// a length byte, that many payload bytes and a CRC-16 (LE), XMODEM flavor,
// computed over everything between the sync byte and the CRC field.
// Output stream (m_*): exactly one item per input item. m_tuser carries the
// event: none, payload byte (forwarded immediately, index in byte_index),
// frame good, or CRC mismatch. Payload is not buffered; drop it on a mismatch.
// An accepted item sits in the input register until the parser takes it, is
// parsed and lands in the result register, which raises m_tvalid.
// Throughput is one item per cycle while m_tready stays high, set by the single
// parse step (one CRC byte update) between the two registers.
// When m_tready is low the result register holds; one more item waits in the
// input register, after which s_tready drops.
// Reset (rst, synchronous): parser hunting, CRC and header cleared, both
// stages empty, sync_byte back to 0x55. APB: sync_byte at address 0.
module framed_packet_parser_crc16 (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // data_byte[7:0], byte_index[15:8], message_type[31:16],
                                 // src_id[47:32], payload_len[55:48]
  output logic [1:0]  m_tuser    // event_res[1:0]
);

  logic              [7:0] sync_byte;
  fpp_pkg::in_item_t item;
  fpp_pkg::result_t  res;
  logic              take;
  logic              sel_sync;

  assign pready   = 1'b1;
  assign sel_sync = (paddr[2] == fpp_pkg::REG_SYNC_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= fpp_pkg::SYNC_RESET;
    end else if (psel && penable && pwrite && pready && sel_sync) begin
      sync_byte <= pwdata[7:0];
    end
  end

  assign prdata = sel_sync ? {24'd0, sync_byte} : 32'd0;

  fpp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .item     (item),
    .take     (take)
  );

  fpp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_byte),
    .item      (item),
    .take      (take),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.payload_len, res.src_id, res.message_type,
                    res.byte_index, res.data_byte};
  assign m_tuser = res.event_res;

endmodule
